// ===== design/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg: shared constants for the consistent-hash ring router.
// Holds ring geometry, operation and status codes, and the mix constants.
// ----------------------------------------------------------------------------
package chr_pkg;

   localparam int MAX_SERVERS = 64;
   localparam int REPLICAS    = 3;
   localparam int RING_CAP    = MAX_SERVERS * REPLICAS;
   localparam int IDX_W       = $clog2(RING_CAP);
   localparam int CNT_W       = $clog2(RING_CAP + 1);
   localparam int REP_W       = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
   localparam int ID_W        = 17;
   localparam int HASH_W      = 32;
   localparam int ENTRY_W     = HASH_W + ID_W;

   localparam logic [31:0] MIX_MUL      = 32'h045d9f3b;
   localparam logic [31:0] DJB_SEED     = 32'd5381;
   localparam logic [31:0] REPLICA_STEP = 32'd100000;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_KEY    = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

endpackage

// ===== design/chr_ram.sv =====
// ----------------------------------------------------------------------------
// chr_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module chr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/chr_mix.sv =====
// ----------------------------------------------------------------------------
// chr_mix: multi-cycle integer mix hash.
// Two multiply rounds, one multiplier use per cycle.
// ----------------------------------------------------------------------------
module chr_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] din,
   output logic        done,
   output logic [31:0] dout
);

   logic [31:0] x_ff, x_in;
   logic [1:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [31:0] fold;

   assign fold = (x_ff >> 16) ^ x_ff;

   // One fold and multiply per cycle; the last step only folds.
   always_comb begin
      x_in    = x_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = din;
         step_in = 2'd1;
      end else if (step_ff != 2'd0) begin
         if (step_ff == 2'd3) begin
            x_in    = fold;
            step_in = 2'd0;
            done_in = 1'b1;
         end else begin
            x_in    = fold * chr_pkg::MIX_MUL;
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
   end

   assign done = done_ff;
   assign dout = x_ff;

endmodule

// ===== design/consistent_hash_ring_router.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_router: sorted ring of replica points in one RAM.
// One word is in work at a time, and the ring RAM's single read port paces
// the ring walks. Reset empties the ring and reseeds the key hash; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module consistent_hash_ring_router (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [16:0] req_server_id,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_owner_server,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_op_done
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MIX    = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_SHIFT  = 8'b0000_1000,
      S_RMSCAN = 8'b0001_0000,
      S_LOOK   = 8'b0010_0000,
      S_LKRD   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   localparam int IW = chr_pkg::IDX_W;
   localparam int CW = chr_pkg::CNT_W;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           acc_ff, acc_in;
   logic [31:0]           khash_ff, khash_in;
   logic [16:0]           id_ff, id_in;
   logic [1:0]            mode_ff, mode_in;
   logic [chr_pkg::REP_W-1:0] rep_ff, rep_in;
   logic [31:0]           phash_ff, phash_in;
   logic [CW-1:0]         ptr_ff, ptr_in;     // read pointer
   logic [CW-1:0]         wp_ff, wp_in;       // write pointer
   logic                  rdv_ff, rdv_in;     // read data valid
   logic                  found_ff, found_in;
   logic [16:0]           rsp_owner_ff, rsp_owner_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [1:0]            rsp_op_ff, rsp_op_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [chr_pkg::ENTRY_W-1:0] wr_data, rd_data;
   logic [31:0]           rd_hash;
   logic [16:0]           rd_srv;
   logic                  mix_start, mix_done;
   logic [31:0]           mix_din, mix_dout;
   logic                  accept;
   logic [31:0]           acc_next;

   assign rd_hash = rd_data[chr_pkg::ENTRY_W-1 -: 32];
   assign rd_srv  = rd_data[16:0];

   chr_ram #(.WIDTH(chr_pkg::ENTRY_W), .DEPTH(chr_pkg::RING_CAP)) u_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   chr_mix u_mix (
      .clock(clock), .reset(reset), .start(mix_start), .din(mix_din),
      .done(mix_done), .dout(mix_dout)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign acc_next  = (acc_ff << 5) + acc_ff + {24'd0, req_key_byte};
   assign mix_din   = {15'd0, id_ff}
                      + 32'({rep_ff} * chr_pkg::REPLICA_STEP);

   // Sequencer: insert scans from the top down, shifting points up until the
   // slot for the new hash is found; remove compacts; lookup scans upward.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      khash_in      = khash_ff;
      id_in         = id_ff;
      mode_in       = mode_ff;
      rep_in        = rep_ff;
      phash_in      = phash_ff;
      ptr_in        = ptr_ff;
      wp_in         = wp_ff;
      rdv_in        = 1'b0;
      found_in      = found_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_status_in = rsp_status_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      mix_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in   = req_server_id;
               mode_in = req_mode;
               case (req_mode)
                  chr_pkg::MODE_ADD: begin
                     if (32'(count_ff) + chr_pkg::REPLICAS > chr_pkg::RING_CAP) begin
                        rsp_owner_in = '0; rsp_status_in = chr_pkg::ST_FULL;
                        rsp_op_in = chr_pkg::MODE_ADD; rsp_valid_in = 1'b1;
                     end else begin
                        rep_in   = '0;
                        found_in = 1'b0;
                        state_in = S_MIX;
                        mix_start = 1'b0;
                     end
                  end
                  chr_pkg::MODE_REMOVE: begin
                     ptr_in   = '0;
                     wp_in    = '0;
                     found_in = 1'b0;
                     state_in = S_RMSCAN;
                  end
                  chr_pkg::MODE_KEY: begin
                     if (!req_key_last) begin
                        acc_in = acc_next;
                     end else begin
                        acc_in   = chr_pkg::DJB_SEED;
                        khash_in = acc_next;
                        if (count_ff == '0) begin
                           rsp_owner_in = '0; rsp_status_in = chr_pkg::ST_EMPTY;
                           rsp_op_in = chr_pkg::MODE_KEY; rsp_valid_in = 1'b1;
                        end else begin
                           ptr_in   = '0;
                           state_in = S_LOOK;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_MIX: begin
            // First cycle here launches the mix; wait for its result.
            if (!rdv_ff && !mix_done && !found_ff) begin
               mix_start = 1'b1;
               found_in  = 1'b1;
            end else if (mix_done) begin
               found_in = 1'b0;
               phash_in = mix_dout;
               wp_in    = count_ff;
               if (count_ff == '0) begin
                  state_in = S_SHIFT;
               end else begin
                  rd_addr  = IW'(count_ff - 1'b1);
                  rdv_in   = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // rd_data holds entry wp-1.
            if (rdv_ff) begin
               if (rd_hash > phash_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = IW'(wp_ff);
                  wr_data = rd_data;
                  wp_in   = wp_ff - 1'b1;
                  if (wp_ff == CW'(1)) begin
                     state_in = S_SHIFT;
                  end else begin
                     rd_addr = IW'(wp_ff - CW'(2));
                     rdv_in  = 1'b1;
                  end
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            // Place the new point and move to the next replica, or report OK after the last.
            wr_en    = 1'b1;
            wr_addr  = IW'(wp_ff);
            wr_data  = {phash_ff, id_ff};
            count_in = count_ff + 1'b1;
            if (32'(rep_ff) == chr_pkg::REPLICAS - 1) begin
               rsp_owner_in = '0; rsp_status_in = chr_pkg::ST_OK;
               rsp_op_in = chr_pkg::MODE_ADD; rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rep_in   = rep_ff + 1'b1;
               state_in = S_MIX;
            end
         end

         S_RMSCAN: begin
            // Issue reads in order; compact entries whose id differs.
            if (rdv_ff) begin
               if (rd_srv == id_ff) begin
                  found_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = IW'(wp_ff);
                  wr_data = rd_data;
                  wp_in   = wp_ff + 1'b1;
               end
            end
            if (ptr_ff < count_ff && !rdv_ff) begin
               rd_addr = IW'(ptr_ff);
               ptr_in  = ptr_ff + 1'b1;
               rdv_in  = 1'b1;
            end else if (!rdv_ff) begin
               count_in      = wp_ff;
               rsp_owner_in  = '0;
               rsp_status_in = found_ff ? chr_pkg::ST_OK : chr_pkg::ST_ABSENT;
               rsp_op_in     = chr_pkg::MODE_REMOVE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_LOOK: begin
            rd_addr  = IW'(ptr_ff);
            rdv_in   = 1'b1;
            state_in = S_LKRD;
         end

         S_LKRD: begin
            if (khash_ff <= rd_hash) begin
               rsp_owner_in = rd_srv; rsp_status_in = chr_pkg::ST_OK;
               rsp_op_in = chr_pkg::MODE_KEY; rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (ptr_ff + 1'b1 >= count_ff) begin
               ptr_in   = '0;
               state_in = S_OUT;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_LOOK;
            end
         end

         S_OUT: begin
            // Wrap: read entry zero and report it.
            if (!rdv_ff) begin
               rd_addr = '0;
               rdv_in  = 1'b1;
            end else begin
               rsp_owner_in = rd_srv; rsp_status_in = chr_pkg::ST_OK;
               rsp_op_in = chr_pkg::MODE_KEY; rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         acc_ff       <= chr_pkg::DJB_SEED;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      khash_ff      <= khash_in;
      id_ff         <= id_in;
      mode_ff       <= mode_in;
      rep_ff        <= rep_in;
      phash_ff      <= phash_in;
      ptr_ff        <= ptr_in;
      wp_ff         <= wp_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_op_ff     <= rsp_op_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_owner_server = rsp_owner_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_op_done      = rsp_op_ff;

endmodule
